// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- hdl/bcgd_pkg.sv -----
// ----------------------------------------------------------------------------
// Button gesture detector package
// Shared types, register indexes and reset values of the gesture detector.
// ----------------------------------------------------------------------------
`default_nettype none

package bcgd_pkg;

	localparam int BUTTON_COUNT_DEF = 8;
	localparam int MASK_W = 8;
	localparam int TIMER_W = 16;
	localparam int DIV_STEPS = TIMER_W;
	localparam int STEP_W = $clog2(DIV_STEPS);
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [2:0] REG_TICK_PERIOD = 3'd0;
	localparam logic [2:0] REG_DEBOUNCE = 3'd1;
	localparam logic [2:0] REG_LONG_PRESS = 3'd2;
	localparam logic [2:0] REG_REPEAT = 3'd3;
	localparam logic [2:0] REG_DBL_WINDOW = 3'd4;
	localparam logic [2:0] REG_LONG_ON_REL = 3'd5;
	localparam logic [2:0] REG_REPEAT_EN = 3'd6;

	localparam logic [TIMER_W-1:0] TICK_PERIOD_RST = 16'd10;
	localparam logic [TIMER_W-1:0] DEBOUNCE_RST = 16'd20;
	localparam logic [TIMER_W-1:0] LONG_PRESS_RST = 16'd1000;
	localparam logic [TIMER_W-1:0] REPEAT_RST = 16'd200;
	localparam logic [TIMER_W-1:0] DBL_WINDOW_RST = 16'd300;

	typedef struct packed {
		logic [TIMER_W-1:0] tick_period;
		logic [TIMER_W-1:0] debounce_time;
		logic [TIMER_W-1:0] long_press_time;
		logic [TIMER_W-1:0] repeat_interval;
		logic [TIMER_W-1:0] double_click_window;
		logic long_on_release;
		logic repeat_enable;
	} cfg_t;

	typedef struct packed {
		logic start;
		logic step;
		logic commit;
	} lane_ctrl_t;

	typedef struct packed {
		logic click;
		logic dbl;
		logic lng;
	} lane_ev_t;

endpackage

`default_nettype wire

// ----- hdl/bcgd_lane.sv -----
// ----------------------------------------------------------------------------
// Button lane
// Gesture state machine, saturating timer and bit-serial remainder unit of
// one button.
// ----------------------------------------------------------------------------
`default_nettype none

module bcgd_lane (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire bcgd_pkg::lane_ctrl_t  ctrl,
	input  wire bcgd_pkg::cfg_t        cfg,
	input  wire logic                  lvl,
	output bcgd_pkg::lane_ev_t         ev
);

	typedef enum logic [2:0] {
		M_IDLE     = 3'd0,
		M_DEB      = 3'd1,
		M_PRESSED  = 3'd2,
		M_RELEASED = 3'd3,
		M_DEB2     = 3'd4,
		M_PRESS2   = 3'd5
	} mode_t;

	mode_t mode_q;
	logic [bcgd_pkg::TIMER_W-1:0] timer_q;
	logic [bcgd_pkg::TIMER_W-1:0] dividend_q;
	logic [bcgd_pkg::TIMER_W-1:0] rem_q;

	logic [bcgd_pkg::TIMER_W:0]   rem_shift;
	logic [bcgd_pkg::TIMER_W:0]   rem_diff;
	logic [bcgd_pkg::TIMER_W:0]   tsum;
	logic [bcgd_pkg::TIMER_W-1:0] t_new;
	logic [bcgd_pkg::TIMER_W-1:0] delta;
	logic [bcgd_pkg::TIMER_W:0]   rem_plus;
	logic                         rep_hit;
	logic                         cross_hit;
	mode_t                        mode_d;
	logic [bcgd_pkg::TIMER_W-1:0] timer_d;
	bcgd_pkg::lane_ev_t           ev_d;

	// The repeat count grows when the remainder of the held time past the
	// threshold plus this tick's increment reaches the interval.
	assign rem_shift = {rem_q, dividend_q[bcgd_pkg::TIMER_W-1]};
	assign rem_diff = rem_shift - {1'b0, cfg.repeat_interval};
	assign tsum = {1'b0, timer_q} + {1'b0, cfg.tick_period};
	assign t_new = tsum[bcgd_pkg::TIMER_W] ? '1 : tsum[bcgd_pkg::TIMER_W-1:0];
	assign delta = t_new - timer_q;
	assign rem_plus = {1'b0, rem_q} + {1'b0, delta};
	assign rep_hit = cfg.repeat_enable && (cfg.repeat_interval != '0) &&
		(timer_q >= cfg.long_press_time) &&
		(rem_plus >= {1'b0, cfg.repeat_interval});
	assign cross_hit = (timer_q < cfg.long_press_time) && (t_new >= cfg.long_press_time);

	always_comb begin
		mode_d = mode_q;
		timer_d = t_new;
		ev_d = '0;
		case (mode_q)
			M_DEB: begin
				if (t_new > cfg.debounce_time) begin
					if (lvl) begin
						mode_d = M_PRESSED;
						timer_d = '0;
					end else begin
						mode_d = M_IDLE;
					end
				end
			end
			M_PRESSED: begin
				if (!lvl) begin
					if (t_new < cfg.long_press_time) begin
						mode_d = M_RELEASED;
						timer_d = '0;
					end else begin
						mode_d = M_IDLE;
						ev_d.lng = cfg.long_on_release;
					end
				end
				if (!cfg.long_on_release && (cross_hit || rep_hit)) begin
					ev_d.lng = 1'b1;
				end
			end
			M_RELEASED: begin
				if (t_new <= cfg.double_click_window) begin
					if ((t_new > cfg.debounce_time) && lvl) begin
						mode_d = M_DEB2;
						timer_d = '0;
					end
				end else begin
					mode_d = M_IDLE;
					ev_d.click = 1'b1;
				end
			end
			M_DEB2: begin
				if (t_new > cfg.debounce_time) begin
					if (lvl) begin
						mode_d = M_PRESS2;
						timer_d = '0;
					end else begin
						mode_d = M_IDLE;
						ev_d.click = 1'b1;
					end
				end
			end
			M_PRESS2: begin
				if (!lvl) begin
					mode_d = M_IDLE;
					ev_d.dbl = 1'b1;
				end
			end
			default: begin
				timer_d = timer_q;
				mode_d = lvl ? M_DEB : M_IDLE;
				if (lvl) begin
					timer_d = '0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			timer_q <= '0;
		end else if (ctrl.commit) begin
			mode_q <= mode_d;
			timer_q <= timer_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			dividend_q <= timer_q - cfg.long_press_time;
			rem_q <= '0;
		end else if (ctrl.step) begin
			dividend_q <= {dividend_q[bcgd_pkg::TIMER_W-2:0], 1'b0};
			if (!rem_diff[bcgd_pkg::TIMER_W]) begin
				rem_q <= rem_diff[bcgd_pkg::TIMER_W-1:0];
			end else begin
				rem_q <= rem_shift[bcgd_pkg::TIMER_W-1:0];
			end
		end
	end

	assign ev = ctrl.commit ? ev_d : '0;

endmodule

`default_nettype wire

// ----- hdl/bcgd_merge.sv -----
// ----------------------------------------------------------------------------
// Event merge
// Gathers the lane events into the click, double click and long press masks.
// ----------------------------------------------------------------------------
`default_nettype none

module bcgd_merge #(
	parameter int BUTTON_COUNT = bcgd_pkg::BUTTON_COUNT_DEF
) (
	input  wire bcgd_pkg::lane_ev_t           lane_ev [BUTTON_COUNT],
	output logic [bcgd_pkg::MASK_W-1:0]       click_mask,
	output logic [bcgd_pkg::MASK_W-1:0]       double_click_mask,
	output logic [bcgd_pkg::MASK_W-1:0]       long_press_mask
);

	localparam int SHOWN = (BUTTON_COUNT < bcgd_pkg::MASK_W) ? BUTTON_COUNT
		: bcgd_pkg::MASK_W;

	always_comb begin
		click_mask = '0;
		double_click_mask = '0;
		long_press_mask = '0;
		for (int b = 0; b < SHOWN; b++) begin
			click_mask[b] = lane_ev[b].click;
			double_click_mask[b] = lane_ev[b].dbl;
			long_press_mask[b] = lane_ev[b].lng;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/button_click_gesture_detector.sv -----
// Each accepted item is loaded, passes the 16-step bit-serial remainder unit in each
// button lane and is then committed to the registered output. A new item is taken
// only once the previous one has been committed.
// A result waiting at the output stalls the commit, and with it the next acceptance.
// Reset: all buttons go idle with zero timers, registers take their defaults.
// ----------------------------------------------------------------------------
// Button click gesture detector
// Per-button debounce, click, double click and long press detection over a
// stream of polling ticks, with lanes working side by side.
// ----------------------------------------------------------------------------
`default_nettype none

module button_click_gesture_detector #(
	parameter int BUTTON_COUNT = bcgd_pkg::BUTTON_COUNT_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [7:0]                    s_tdata,  // levels[7:0]
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// click_mask[7:0], double_click_mask[15:8], long_press_mask[23:16]
	output logic [23:0]                        m_tdata,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [bcgd_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [bcgd_pkg::DATA_W-1:0]   pwdata,
	output logic [bcgd_pkg::DATA_W-1:0]        prdata,
	output logic                               pready
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t state_q;
	logic [bcgd_pkg::STEP_W-1:0] cnt_q;
	logic [bcgd_pkg::MASK_W-1:0] levels_q;
	bcgd_pkg::cfg_t cfg_q;
	logic m_tvalid_q;
	logic [23:0] m_tdata_q;

	logic accept;
	logic out_free;
	logic cfg_wr;
	logic [2:0] reg_idx;
	bcgd_pkg::lane_ctrl_t ctrl;
	bcgd_pkg::lane_ev_t lane_ev [BUTTON_COUNT];
	logic [bcgd_pkg::MASK_W-1:0] click_mask;
	logic [bcgd_pkg::MASK_W-1:0] double_click_mask;
	logic [bcgd_pkg::MASK_W-1:0] long_press_mask;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_period <= bcgd_pkg::TICK_PERIOD_RST;
			cfg_q.debounce_time <= bcgd_pkg::DEBOUNCE_RST;
			cfg_q.long_press_time <= bcgd_pkg::LONG_PRESS_RST;
			cfg_q.repeat_interval <= bcgd_pkg::REPEAT_RST;
			cfg_q.double_click_window <= bcgd_pkg::DBL_WINDOW_RST;
			cfg_q.long_on_release <= 1'b0;
			cfg_q.repeat_enable <= 1'b0;
		end else if (cfg_wr) begin
			case (reg_idx)
				bcgd_pkg::REG_TICK_PERIOD: cfg_q.tick_period <= pwdata[15:0];
				bcgd_pkg::REG_DEBOUNCE:    cfg_q.debounce_time <= pwdata[15:0];
				bcgd_pkg::REG_LONG_PRESS:  cfg_q.long_press_time <= pwdata[15:0];
				bcgd_pkg::REG_REPEAT:      cfg_q.repeat_interval <= pwdata[15:0];
				bcgd_pkg::REG_DBL_WINDOW:  cfg_q.double_click_window <= pwdata[15:0];
				bcgd_pkg::REG_LONG_ON_REL: cfg_q.long_on_release <= pwdata[0];
				bcgd_pkg::REG_REPEAT_EN:   cfg_q.repeat_enable <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx)
			bcgd_pkg::REG_TICK_PERIOD: prdata[15:0] = cfg_q.tick_period;
			bcgd_pkg::REG_DEBOUNCE:    prdata[15:0] = cfg_q.debounce_time;
			bcgd_pkg::REG_LONG_PRESS:  prdata[15:0] = cfg_q.long_press_time;
			bcgd_pkg::REG_REPEAT:      prdata[15:0] = cfg_q.repeat_interval;
			bcgd_pkg::REG_DBL_WINDOW:  prdata[15:0] = cfg_q.double_click_window;
			bcgd_pkg::REG_LONG_ON_REL: prdata[0] = cfg_q.long_on_release;
			bcgd_pkg::REG_REPEAT_EN:   prdata[0] = cfg_q.repeat_enable;
			default: ;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign ctrl.start = accept;
	assign ctrl.step = (state_q == ST_DIV);
	assign ctrl.commit = (state_q == ST_FIN) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (ctrl.commit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DIV;
						cnt_q <= '0;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == bcgd_pkg::STEP_W'(bcgd_pkg::DIV_STEPS - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			levels_q <= s_tdata;
		end
		if (ctrl.commit) begin
			m_tdata_q <= {long_press_mask, double_click_mask, click_mask};
		end
	end

	for (genvar b = 0; b < BUTTON_COUNT; b++) begin : g_lane
		logic lvl;
		if (b < bcgd_pkg::MASK_W) begin : g_seen
			assign lvl = levels_q[b];
		end else begin : g_dark
			assign lvl = 1'b0;
		end
		bcgd_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.cfg    (cfg_q),
			.lvl    (lvl),
			.ev     (lane_ev[b])
		);
	end

	bcgd_merge #(
		.BUTTON_COUNT (BUTTON_COUNT)
	) u_merge (
		.lane_ev           (lane_ev),
		.click_mask        (click_mask),
		.double_click_mask (double_click_mask),
		.long_press_mask   (long_press_mask)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

endmodule

`default_nettype wire

// ----- hdl/bcgd_checker.sv -----
// ----------------------------------------------------------------------------
// Gesture detector port checker
// Checks the port behavior of the gesture detector over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bcgd_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        s_tvalid,
	input wire logic                        s_tready,
	input wire logic                        m_tvalid,
	input wire logic                        m_tready,
	input wire logic [23:0]                 m_tdata
);

	logic in_acc;
	logic [7:0] ev_overlap;

	assign in_acc = s_tvalid && s_tready;
	assign ev_overlap = (m_tdata[7:0] & m_tdata[15:8]) | (m_tdata[7:0] & m_tdata[23:16]) |
		(m_tdata[15:8] & m_tdata[23:16]);

	// A button raises at most one kind of event per item.
	`ASSERT_IMPL(a_one_event, clk, arst_n, m_tvalid, ev_overlap == 8'd0)
	// Each item is worked on alone, so the input closes right after an acceptance.
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_acc, !s_tready)
	// A result never appears in the cycle right after its item arrives.
	`ASSERT_NEXT(a_no_early_result, clk, arst_n, in_acc, !$rose(m_tvalid))
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata))

endmodule

bind button_click_gesture_detector bcgd_checker u_bcgd_checker (.*);

`default_nettype wire

// ----- verif/gesture_monitor.sv -----
// ----------------------------------------------------------------------------
// Gesture detector monitor
// Watches the register port and both streams of the gesture detector. Keeps
// its own copy of the registers and of every button's mode and timer, works
// out the three event masks for each accepted item, and compares each result
// item field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module gesture_monitor import bcgd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [7:0]        s_tdata,
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [23:0]       m_tdata,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output int                fail_count,
	output int                pending_count,
	output int                results_seen,
	output int                events_seen
);

	typedef enum logic [2:0] {
		BTN_IDLE      = 3'd0,
		BTN_DEBOUNCE  = 3'd1,
		BTN_DOWN      = 3'd2,
		BTN_RELEASED  = 3'd3,
		BTN_DEBOUNCE2 = 3'd4,
		BTN_DOWN2     = 3'd5
	} btn_mode_e;

	cfg_t        regs;
	btn_mode_e   btn_mode [8];
	logic [15:0] btn_timer [8];
	logic [23:0] pending_masks [$];
	logic [23:0] want;
	int          fld;

	// Returns {long_press_mask, double_click_mask, click_mask} for one tick.
	function automatic logic [23:0] advance_buttons(input logic [7:0] lv);
		int          b;
		logic [16:0] sum;
		logic [15:0] prev;
		logic [15:0] t;
		int unsigned q0;
		int unsigned q1;
		logic [7:0]  clicks;
		logic [7:0]  doubles;
		logic [7:0]  longs;
		clicks = '0;
		doubles = '0;
		longs = '0;
		for (b = 0; b < 8; b++) begin
			prev = btn_timer[b];
			sum = {1'b0, prev} + {1'b0, regs.tick_period};
			t = sum[16] ? 16'hFFFF : sum[15:0];
			case (btn_mode[b])
				BTN_DEBOUNCE: begin
					btn_timer[b] = t;
					if (t > regs.debounce_time) begin
						if (lv[b]) begin
							btn_mode[b] = BTN_DOWN;
							btn_timer[b] = '0;
						end else begin
							btn_mode[b] = BTN_IDLE;
						end
					end
				end
				BTN_DOWN: begin
					btn_timer[b] = t;
					if (!lv[b]) begin
						if (t < regs.long_press_time) begin
							btn_mode[b] = BTN_RELEASED;
							btn_timer[b] = '0;
						end else begin
							btn_mode[b] = BTN_IDLE;
							if (regs.long_on_release)
								longs[b] = 1'b1;
						end
					end
					if (!regs.long_on_release) begin
						if (prev < regs.long_press_time && t >= regs.long_press_time) begin
							longs[b] = 1'b1;
						end else if (regs.repeat_enable && regs.repeat_interval != '0 &&
								prev >= regs.long_press_time) begin
							q0 = (32'(prev) - 32'(regs.long_press_time)) /
								32'(regs.repeat_interval);
							q1 = (32'(t) - 32'(regs.long_press_time)) /
								32'(regs.repeat_interval);
							if (q1 > q0)
								longs[b] = 1'b1;
						end
					end
				end
				BTN_RELEASED: begin
					btn_timer[b] = t;
					if (t <= regs.double_click_window) begin
						if (t > regs.debounce_time && lv[b]) begin
							btn_mode[b] = BTN_DEBOUNCE2;
							btn_timer[b] = '0;
						end
					end else begin
						btn_mode[b] = BTN_IDLE;
						clicks[b] = 1'b1;
					end
				end
				BTN_DEBOUNCE2: begin
					btn_timer[b] = t;
					if (t > regs.debounce_time) begin
						if (lv[b]) begin
							btn_mode[b] = BTN_DOWN2;
							btn_timer[b] = '0;
						end else begin
							btn_mode[b] = BTN_IDLE;
							clicks[b] = 1'b1;
						end
					end
				end
				BTN_DOWN2: begin
					btn_timer[b] = t;
					if (!lv[b]) begin
						btn_mode[b] = BTN_IDLE;
						doubles[b] = 1'b1;
					end
				end
				default: begin
					if (lv[b]) begin
						btn_mode[b] = BTN_DEBOUNCE;
						btn_timer[b] = '0;
					end else begin
						btn_mode[b] = BTN_IDLE;
					end
				end
			endcase
		end
		return {longs, doubles, clicks};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.tick_period = TICK_PERIOD_RST;
			regs.debounce_time = DEBOUNCE_RST;
			regs.long_press_time = LONG_PRESS_RST;
			regs.repeat_interval = REPEAT_RST;
			regs.double_click_window = DBL_WINDOW_RST;
			regs.long_on_release = 1'b0;
			regs.repeat_enable = 1'b0;
			foreach (btn_mode[i]) begin
				btn_mode[i] = BTN_IDLE;
				btn_timer[i] = '0;
			end
			pending_masks.delete();
			fail_count = 0;
			pending_count = 0;
			results_seen = 0;
			events_seen = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_TICK_PERIOD: regs.tick_period = pwdata[15:0];
					REG_DEBOUNCE:    regs.debounce_time = pwdata[15:0];
					REG_LONG_PRESS:  regs.long_press_time = pwdata[15:0];
					REG_REPEAT:      regs.repeat_interval = pwdata[15:0];
					REG_DBL_WINDOW:  regs.double_click_window = pwdata[15:0];
					REG_LONG_ON_REL: regs.long_on_release = pwdata[0];
					REG_REPEAT_EN:   regs.repeat_enable = pwdata[0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				results_seen++;
				events_seen += $countones(m_tdata);
				if (pending_masks.size() == 0) begin
					$display("%0t: result %06h arrived with no item outstanding",
						$time, m_tdata);
					fail_count++;
				end else begin
					want = pending_masks.pop_front();
					for (fld = 0; fld < 3; fld++) begin
						if (m_tdata[8*fld +: 8] !== want[8*fld +: 8]) begin
							$display("%0t: %s mismatch, expected %02h, actual %02h", $time,
								fld == 0 ? "click_mask" :
								fld == 1 ? "double_click_mask" : "long_press_mask",
								want[8*fld +: 8], m_tdata[8*fld +: 8]);
							fail_count++;
						end
					end
				end
			end
			if (s_tvalid && s_tready)
				pending_masks.push_back(advance_buttons(s_tdata));
			pending_count = pending_masks.size();
		end
	end

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// Gesture detector testbench
// Drives polling ticks into the gesture detector under a series of register
// settings: the reset values, hand-picked ones with extreme values and random
// ones. Per-button press and release runs of random length produce clicks,
// double clicks and long presses, mixed with bounces and noise. Both streams
// idle at random, and once the output is held off long enough to stall the
// input. The monitor predicts and checks every result item.
// ----------------------------------------------------------------------------
module tb_top;
	import bcgd_pkg::*;

	localparam logic [2:0] REG_UNUSED = 3'd7;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [7:0]        s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	logic [23:0]       m_tdata;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	int fail_count;
	int pending_count;
	int results_seen;
	int events_seen;
	int items_sent = 0;
	int settings_used = 0;
	int hold_left = 0;
	bit hold_off_req = 1'b0;
	bit quiet = 1'b0;
	bit lvl_state [8];
	int run_left [8];
	logic [63:0] directed_lv = 64'h55AA_00FF_FFFF_FF00;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	button_click_gesture_detector u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	gesture_monitor u_monitor (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.results_seen  (results_seen),
		.events_seen   (events_seen)
	);

	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

	// The output side: short random stalls, and one long hold-off on request.
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left = 299;
				m_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				hold_left = $urandom_range(0, 2);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_item(input logic [7:0] lv);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= lv;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic apb_write(input logic [2:0] idx, input logic [15:0] val, input int width);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= (DATA_W'($urandom) << width) | DATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_regs(input logic [15:0] tp, input logic [15:0] deb,
			input logic [15:0] lpt, input logic [15:0] ri, input logic [15:0] win,
			input logic lor, input logic rep);
		apb_write(REG_TICK_PERIOD, tp, 16);
		apb_write(REG_DEBOUNCE, deb, 16);
		apb_write(REG_LONG_PRESS, lpt, 16);
		apb_write(REG_REPEAT, ri, 16);
		apb_write(REG_DBL_WINDOW, win, 16);
		apb_write(REG_LONG_ON_REL, 16'(lor), 1);
		apb_write(REG_REPEAT_EN, 16'(rep), 1);
		settings_used++;
	endtask

	// Lets every outstanding item come out before the registers change.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending_count == 0);
		repeat (24) @(posedge clk);
	endtask

	// Each button holds its level for a run of random length, from a bounce up to
	// max_run ticks or 12 ticks, whichever is more; now and then a tick of pure noise is sent instead.
	function automatic logic [7:0] next_levels(input int max_run);
		logic [7:0] lv;
		int         r;
		if ($urandom_range(0, 11) == 0)
			return 8'($urandom_range(0, 255));
		for (int b = 0; b < 8; b++) begin
			if (run_left[b] == 0) begin
				r = $urandom_range(0, 9);
				lvl_state[b] = !lvl_state[b];
				if (r < 2)
					run_left[b] = $urandom_range(1, 2);
				else if (r < 6)
					run_left[b] = $urandom_range(3, 12);
				else if (r < 9)
					run_left[b] = $urandom_range(8, max_run / 3 + 8);
				else
					run_left[b] = $urandom_range(max_run / 2, max_run);
			end
			run_left[b]--;
			lv[b] = lvl_state[b];
		end
		return lv;
	endfunction

	task automatic run_random(input int n, input int max_run);
		repeat (n) send_item(next_levels(max_run));
	endtask

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: all-zero and all-one levels, alternating bits.
		settings_used++;
		for (int i = 0; i < 8; i++)
			send_item(directed_lv[8*i +: 8]);
		run_random(100, 130);
		drain();

		// All buttons released on the very tick the long press time is reached,
		// then a long output hold-off while items keep coming.
		program_regs(10, 20, 60, 20, 60, 1'b0, 1'b1);
		repeat (8) send_item(8'h00);
		repeat (9) send_item(8'hFF);
		send_item(8'h00);
		hold_off_req = 1'b1;
		run_random(150, 30);
		drain();

		// Long press reported on release.
		program_regs(10, 20, 40, 20, 60, 1'b1, 1'b1);
		run_random(120, 25);
		drain();

		// Timer reaches full scale on the first tick; a zero double-click window.
		program_regs(16'hFFFF, 0, 16'hFFFF, 1, 0, 1'b0, 1'b1);
		run_random(80, 6);
		drain();

		// Zero long press time and the widest window, with no idling at all.
		quiet = 1'b1;
		program_regs(1, 0, 0, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1);
		run_random(80, 20);
		drain();
		quiet = 1'b0;

		// Zero repeat interval; a write to the unused address is ignored.
		program_regs(7, 13, 50, 0, 40, 1'b0, 1'b1);
		apb_write(REG_UNUSED, 16'($urandom), 16);
		run_random(100, 25);
		drain();

		for (int k = 0; k < 3; k++) begin
			quiet = (k == 2);
			program_regs(16'($urandom_range(1, 20)), 16'($urandom_range(0, 60)),
				16'($urandom_range(0, 300)), 16'($urandom_range(0, 80)),
				16'($urandom_range(0, 200)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
			run_random(60, 40);
			drain();
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending_count == 0);
		repeat (40) @(posedge clk);
		$display("Sent %0d ticks under %0d register settings, incl. one long output stall.",
			items_sent, settings_used);
		$display("Compared %0d results carrying %0d click, double-click and long-press events.",
			results_seen, events_seen);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
